>>> sv/nntt_pkg.sv
// Shared types and constants for the nearest-neighbor track table.
// Used by the entry RAM, the match unit and the top level.
package nntt_pkg;

  localparam int ID_W       = 16;
  localparam int POS_W      = 16;
  localparam int AREA_W     = 20;
  localparam int MISS_W     = 3;
  localparam int RATIO_W    = 9;
  localparam int RATIO_FRAC = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int D2_W       = 2 * POS_W + 1;

  localparam logic [MISS_W-1:0]  MISS_SAT = 3'd7;
  localparam logic [ID_W-1:0]    ID_FIRST = 16'd1;
  localparam logic [ID_W-1:0]    ID_LAST  = 16'hFFFF;

  localparam logic [POS_W-1:0]   GATE_RST      = 16'd800;
  localparam logic [RATIO_W-1:0] RATIO_RST     = 9'd179;
  localparam logic [MISS_W-1:0]  MAX_MISS_RST  = 3'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_GATE_DISTANCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE_RATIO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSES     = 2'd2;

  localparam logic OP_FRAME_START = 1'b0;
  localparam logic OP_DETECTION   = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  x;
    logic [POS_W-1:0]  y;
    logic [AREA_W-1:0] area;
  } entry_t;

  // Sequencer to match unit, one entry issued per cycle.
  typedef struct packed {
    logic clear;
    logic live;
    logic last;
    logic entry_valid;
  } match_ctl_t;

  typedef struct packed {
    logic done;
    logic best_found;
    logic free_found;
  } match_stat_t;

endpackage

>>> sv/nntt_entry_ram.sv
// Track entry storage: id, position and area of each table slot.
// One write port, one read port with registered read data; uses nntt_pkg.
module nntt_entry_ram import nntt_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/nntt_match_unit.sv
// Pipelined gate, size and distance evaluation, one table entry per cycle.
// Tracks the nearest passing entry and the lowest free slot; uses nntt_pkg.
module nntt_match_unit import nntt_pkg::*; #(
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  match_ctl_t         ctl_i,
  input  logic [IDX_W-1:0]   issue_idx_i,
  input  entry_t             rd_entry_i,
  input  logic [POS_W-1:0]   det_x_i,
  input  logic [POS_W-1:0]   det_y_i,
  input  logic [AREA_W-1:0]  det_area_i,
  input  logic [POS_W-1:0]   gate_distance_i,
  input  logic [RATIO_W-1:0] min_size_ratio_i,
  output match_stat_t        stat_o,
  output logic [IDX_W-1:0]   best_idx_o,
  output logic [ID_W-1:0]    best_id_o,
  output logic [IDX_W-1:0]   free_idx_o
);

  localparam int PROD_W = RATIO_W + AREA_W;

  logic [2*POS_W-1:0] gate2_r;

  // tag stage, aligned with the RAM read data
  logic t0_live_r, t0_last_r, t0_v_r;
  logic [IDX_W-1:0] t0_idx_r;

  logic a_live_r, a_last_r, a_v_r;
  logic [IDX_W-1:0]  a_idx_r;
  logic [ID_W-1:0]   a_id_r;
  logic [POS_W-1:0]  a_dx_r, a_dy_r;
  logic [AREA_W-1:0] a_lo_r, a_hi_r;

  logic b_live_r, b_last_r, b_v_r;
  logic [IDX_W-1:0]   b_idx_r;
  logic [ID_W-1:0]    b_id_r;
  logic [2*POS_W-1:0] b_dx2_r, b_dy2_r;
  logic [PROD_W-1:0]  b_rhi_r;
  logic [AREA_W-1:0]  b_lo_r;

  logic c_live_r, c_last_r, c_v_r, c_size_ok_r;
  logic [IDX_W-1:0] c_idx_r;
  logic [ID_W-1:0]  c_id_r;
  logic [D2_W-1:0]  c_d2_r;

  logic             done_r, best_found_r, free_found_r;
  logic [IDX_W-1:0] best_idx_r, free_idx_r;
  logic [ID_W-1:0]  best_id_r;
  logic [D2_W-1:0]  best_d_r;

  logic [POS_W-1:0]  dx_a, dy_a;
  logic [AREA_W-1:0] lo_a, hi_a;
  logic              win_d, take_free_d;

  always_comb begin
    dx_a = (det_x_i > rd_entry_i.x) ? det_x_i - rd_entry_i.x : rd_entry_i.x - det_x_i;
    dy_a = (det_y_i > rd_entry_i.y) ? det_y_i - rd_entry_i.y : rd_entry_i.y - det_y_i;
    lo_a = (det_area_i < rd_entry_i.area) ? det_area_i : rd_entry_i.area;
    hi_a = (det_area_i < rd_entry_i.area) ? rd_entry_i.area : det_area_i;
  end

  // Equal distance goes to the lower id; a full tie keeps the lower index.
  always_comb begin
    win_d = c_live_r && c_v_r && c_size_ok_r && (c_d2_r <= D2_W'(gate2_r)) &&
            (!best_found_r || (c_d2_r < best_d_r) ||
             ((c_d2_r == best_d_r) && (c_id_r < best_id_r)));
    take_free_d = c_live_r && !c_v_r && !free_found_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_live_r    <= 1'b0;
      t0_last_r    <= 1'b0;
      a_live_r     <= 1'b0;
      a_last_r     <= 1'b0;
      b_live_r     <= 1'b0;
      b_last_r     <= 1'b0;
      c_live_r     <= 1'b0;
      c_last_r     <= 1'b0;
      done_r       <= 1'b0;
      best_found_r <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      t0_live_r <= ctl_i.live;
      t0_last_r <= ctl_i.live && ctl_i.last;
      a_live_r  <= t0_live_r;
      a_last_r  <= t0_last_r;
      b_live_r  <= a_live_r;
      b_last_r  <= a_last_r;
      c_live_r  <= b_live_r;
      c_last_r  <= b_last_r;
      done_r    <= c_live_r && c_last_r;
      if (ctl_i.clear) begin
        best_found_r <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        if (win_d) begin
          best_found_r <= 1'b1;
        end
        if (take_free_d) begin
          free_found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    gate2_r  <= gate_distance_i * gate_distance_i;
    t0_v_r   <= ctl_i.entry_valid;
    t0_idx_r <= issue_idx_i;

    a_v_r   <= t0_v_r;
    a_idx_r <= t0_idx_r;
    a_id_r  <= rd_entry_i.id;
    a_dx_r  <= dx_a;
    a_dy_r  <= dy_a;
    a_lo_r  <= lo_a;
    a_hi_r  <= hi_a;

    b_v_r   <= a_v_r;
    b_idx_r <= a_idx_r;
    b_id_r  <= a_id_r;
    b_dx2_r <= a_dx_r * a_dx_r;
    b_dy2_r <= a_dy_r * a_dy_r;
    b_rhi_r <= min_size_ratio_i * a_hi_r;
    b_lo_r  <= a_lo_r;

    c_v_r       <= b_v_r;
    c_idx_r     <= b_idx_r;
    c_id_r      <= b_id_r;
    c_d2_r      <= D2_W'(b_dx2_r) + D2_W'(b_dy2_r);
    c_size_ok_r <= PROD_W'({b_lo_r, {RATIO_FRAC{1'b0}}}) >= b_rhi_r;

    if (win_d) begin
      best_idx_r <= c_idx_r;
      best_id_r  <= c_id_r;
      best_d_r   <= c_d2_r;
    end
    if (take_free_d) begin
      free_idx_r <= c_idx_r;
    end
  end

  assign stat_o.done       = done_r;
  assign stat_o.best_found = best_found_r;
  assign stat_o.free_found = free_found_r;
  assign best_idx_o        = best_idx_r;
  assign best_id_o         = best_id_r;
  assign free_idx_o        = free_idx_r;

endmodule

>>> sv/nearest_neighbor_track_table.sv
// Top level of the nearest-neighbor track table: sequencer, valid and miss
// state, configuration registers and result register. Uses nntt_pkg,
// nntt_entry_ram and nntt_match_unit.
//
// A frame-start transaction gives no result and leaves in_ready high. A
// detection holds in_ready low from its acceptance until its result is loaded,
// so the next detection waits until then. The entry RAM is read one slot per
// cycle. Each slot passes through the four-stage match unit and one more
// register flags the end of the scan. Then come the commit state and the
// done state, which loads the result register. The result register holds a
// finished result until taken, and the next transaction may be accepted
// meanwhile. The load waits while an earlier result is still untaken, which
// holds in_ready low for as long.
// Entry contents have no reset; valid bits and miss counts are cleared.
module nearest_neighbor_track_table import nntt_pkg::*; #(
  parameter int MAX_TRACKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_operation,
  input  logic [POS_W-1:0]      in_pos_x,
  input  logic [POS_W-1:0]      in_pos_y,
  input  logic [AREA_W-1:0]     in_target_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ID_W-1:0]       out_assigned_id,
  output logic                  out_is_new_track,
  output logic                  out_table_full,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TRACKS - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_WAIT   = 5'b00100,
    S_COMMIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [POS_W-1:0]   gate_r;
  logic [RATIO_W-1:0] ratio_r;
  logic [MISS_W-1:0]  max_miss_r;

  logic [MAX_TRACKS-1:0] valid_r, valid_nxt;
  logic [MISS_W-1:0]     misses_r   [MAX_TRACKS];
  logic [MISS_W-1:0]     misses_nxt [MAX_TRACKS];
  logic [ID_W-1:0]       next_id_r, next_id_nxt;
  logic [IDX_W-1:0]      scan_idx_r, scan_idx_nxt;

  logic [POS_W-1:0]  det_x_r, det_y_r;
  logic [AREA_W-1:0] det_area_r;

  logic [ID_W-1:0] res_id_r, res_id_nxt;
  logic            res_new_r, res_new_nxt, res_full_r, res_full_nxt;

  logic            out_valid_r;
  logic [ID_W-1:0] out_id_r;
  logic            out_new_r, out_full_r;

  logic in_fire, cfg_fire, out_load;

  match_ctl_t       mctl;
  match_stat_t      mstat;
  logic [IDX_W-1:0] best_idx, free_idx;
  logic [ID_W-1:0]  best_id;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata, ram_rdata;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_ready);

  nntt_entry_ram #(
    .DEPTH (MAX_TRACKS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  nntt_match_unit #(
    .IDX_W (IDX_W)
  ) u_match (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl_i            (mctl),
    .issue_idx_i      (scan_idx_r),
    .rd_entry_i       (ram_rdata),
    .det_x_i          (det_x_r),
    .det_y_i          (det_y_r),
    .det_area_i       (det_area_r),
    .gate_distance_i  (gate_r),
    .min_size_ratio_i (ratio_r),
    .stat_o           (mstat),
    .best_idx_o       (best_idx),
    .best_id_o        (best_id),
    .free_idx_o       (free_idx)
  );

  always_comb begin
    mctl.clear       = in_fire;
    mctl.live        = (state_r == S_SCAN);
    mctl.last        = (scan_idx_r == LAST_IDX);
    mctl.entry_valid = valid_r[scan_idx_r];
  end

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    valid_nxt    = valid_r;
    misses_nxt   = misses_r;
    next_id_nxt  = next_id_r;
    res_id_nxt   = res_id_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    ram_we       = 1'b0;
    ram_waddr    = best_idx;
    ram_wdata.id   = best_id;
    ram_wdata.x    = det_x_r;
    ram_wdata.y    = det_y_r;
    ram_wdata.area = det_area_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_operation == OP_FRAME_START) begin
            // age every live track, saturating
            for (int i = 0; i < MAX_TRACKS; i++) begin
              if (valid_r[i] && (misses_r[i] != MISS_SAT)) begin
                misses_nxt[i] = misses_r[i] + 1'b1;
              end
            end
          end else begin
            scan_idx_nxt = '0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (scan_idx_r == LAST_IDX) begin
          state_nxt = S_WAIT;
        end else begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      S_WAIT: begin
        if (mstat.done) begin
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        res_new_nxt  = 1'b0;
        res_full_nxt = 1'b0;
        if (mstat.best_found) begin
          ram_we               = 1'b1;
          misses_nxt[best_idx] = '0;
          res_id_nxt           = best_id;
        end else if (mstat.free_found) begin
          ram_we               = 1'b1;
          ram_waddr            = free_idx;
          ram_wdata.id         = next_id_r;
          valid_nxt[free_idx]  = 1'b1;
          misses_nxt[free_idx] = '0;
          res_id_nxt           = next_id_r;
          res_new_nxt          = 1'b1;
          next_id_nxt = (next_id_r == ID_LAST) ? ID_FIRST : next_id_r + 1'b1;
        end else begin
          res_id_nxt   = '0;
          res_full_nxt = 1'b1;
        end
        // drop tracks that missed too many frames
        for (int i = 0; i < MAX_TRACKS; i++) begin
          if (misses_nxt[i] > max_miss_r) begin
            valid_nxt[i] = 1'b0;
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      next_id_r   <= ID_FIRST;
      out_valid_r <= 1'b0;
      gate_r      <= GATE_RST;
      ratio_r     <= RATIO_RST;
      max_miss_r  <= MAX_MISS_RST;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      next_id_r <= next_id_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        case (cfg_index)
          CFG_GATE_DISTANCE:  gate_r     <= cfg_data;
          CFG_MIN_SIZE_RATIO: ratio_r    <= cfg_data[RATIO_W-1:0];
          CFG_MAX_MISSES:     max_miss_r <= cfg_data[MISS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TRACKS; i++) begin
        misses_r[i] <= '0;
      end
    end else begin
      misses_r <= misses_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    res_id_r   <= res_id_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    if (in_fire) begin
      det_x_r    <= in_pos_x;
      det_y_r    <= in_pos_y;
      det_area_r <= in_target_size;
    end
    if (out_load) begin
      out_id_r   <= res_id_r;
      out_new_r  <= res_new_r;
      out_full_r <= res_full_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_assigned_id  = out_id_r;
  assign out_is_new_track = out_new_r;
  assign out_table_full   = out_full_r;

  a_done_only_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mstat.done |-> (state_r == S_WAIT))
    else $error("match unit finished outside the wait state");

  a_next_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    next_id_r != '0)
    else $error("next track id reached zero");

  a_free_slot_unused: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_COMMIT) && !mstat.best_found && mstat.free_found) |->
      !valid_r[free_idx])
    else $error("new track placed in an occupied slot");

  a_match_survives: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_COMMIT) && mstat.best_found) |=> valid_r[$past(best_idx)])
    else $error("matched track was dropped");

endmodule

>>> tb/nntt_checker.sv
// Checker for the nearest-neighbor track table. Watches the input, result and
// register channels, keeps its own copy of the table and compares each result.
// Depends on nntt_pkg.
module nntt_checker import nntt_pkg::*; #(
  parameter int TRACKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_operation,
  input  logic [POS_W-1:0]      in_pos_x,
  input  logic [POS_W-1:0]      in_pos_y,
  input  logic [AREA_W-1:0]     in_target_size,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ID_W-1:0]       out_assigned_id,
  input  logic                  out_is_new_track,
  input  logic                  out_table_full,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ID_W-1:0] assigned_id;
    logic            is_new_track;
    logic            table_full;
  } track_result_t;

  logic [POS_W-1:0]   gate_dist;
  logic [RATIO_W-1:0] ratio_floor;
  logic [MISS_W-1:0]  miss_limit;

  logic               trk_valid  [TRACKS];
  logic [ID_W-1:0]    trk_id     [TRACKS];
  logic [POS_W-1:0]   trk_x      [TRACKS];
  logic [POS_W-1:0]   trk_y      [TRACKS];
  logic [AREA_W-1:0]  trk_area   [TRACKS];
  logic [MISS_W-1:0]  trk_misses [TRACKS];
  logic [ID_W-1:0]    id_counter;

  track_result_t      expected_ids [$];
  track_result_t      seen, want;

  task automatic report(input string msg);
    if (fail_count < 100) $display("[%0t] track table mismatch: %s", $realtime, msg);
    fail_count++;
  endtask

  task automatic clear_table();
    int i;
    gate_dist   = GATE_RST;
    ratio_floor = RATIO_RST;
    miss_limit  = MAX_MISS_RST;
    id_counter  = ID_FIRST;
    for (i = 0; i < TRACKS; i++) begin
      trk_valid[i]  = 1'b0;
      trk_misses[i] = '0;
    end
    expected_ids.delete();
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    case (idx)
      CFG_GATE_DISTANCE:  gate_dist   = value[POS_W-1:0];
      CFG_MIN_SIZE_RATIO: ratio_floor = value[RATIO_W-1:0];
      CFG_MAX_MISSES:     miss_limit  = value[MISS_W-1:0];
      default: ;
    endcase
  endtask

  function automatic void age_tracks();
    int i;
    for (i = 0; i < TRACKS; i++) begin
      if (trk_valid[i] && trk_misses[i] != MISS_SAT) trk_misses[i] = trk_misses[i] + 1'b1;
    end
  endfunction

  function automatic logic area_compatible(input logic [AREA_W-1:0] a, b);
    longint unsigned lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return lo * (1 << RATIO_FRAC) >= 64'(ratio_floor) * hi;
  endfunction

  function automatic track_result_t associate(input logic [POS_W-1:0] px, py,
                                              input logic [AREA_W-1:0] sz);
    track_result_t   res;
    longint unsigned gate_sq, a, b, dx, dy, d2, best_d2;
    int              best, free_idx, i;
    res      = '0;
    best     = -1;
    free_idx = -1;
    best_d2  = 0;
    gate_sq  = 64'(gate_dist) * 64'(gate_dist);
    for (i = 0; i < TRACKS; i++) begin
      if (!trk_valid[i]) begin
        if (free_idx < 0) free_idx = i;
      end else begin
        a  = px;
        b  = trk_x[i];
        dx = (a > b) ? a - b : b - a;
        a  = py;
        b  = trk_y[i];
        dy = (a > b) ? a - b : b - a;
        d2 = dx * dx + dy * dy;
        // nearest gated track wins; equal distance goes to the lower id
        if (d2 <= gate_sq && area_compatible(sz, trk_area[i]) &&
            (best < 0 || d2 < best_d2 || (d2 == best_d2 && trk_id[i] < trk_id[best]))) begin
          best    = i;
          best_d2 = d2;
        end
      end
    end

    if (best >= 0) begin
      trk_x[best]      = px;
      trk_y[best]      = py;
      trk_area[best]   = sz;
      trk_misses[best] = '0;
      res.assigned_id  = trk_id[best];
    end else if (free_idx >= 0) begin
      trk_valid[free_idx]  = 1'b1;
      trk_id[free_idx]     = id_counter;
      trk_x[free_idx]      = px;
      trk_y[free_idx]      = py;
      trk_area[free_idx]   = sz;
      trk_misses[free_idx] = '0;
      res.assigned_id      = id_counter;
      res.is_new_track     = 1'b1;
      id_counter           = (id_counter == ID_LAST) ? ID_FIRST : id_counter + 1'b1;
    end else begin
      res.table_full = 1'b1;
    end

    // drop stale tracks after every detection
    for (i = 0; i < TRACKS; i++) begin
      if (trk_valid[i] && trk_misses[i] > miss_limit) trk_valid[i] = 1'b0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_table();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);

      if (out_valid && out_ready) begin
        seen = '{out_assigned_id, out_is_new_track, out_table_full};
        if (expected_ids.size() == 0) begin
          report($sformatf("result id %0d with no detection waiting", seen.assigned_id));
        end else begin
          want = expected_ids.pop_front();
          if (seen.assigned_id !== want.assigned_id)
            report($sformatf("assigned_id got %0d want %0d", seen.assigned_id,
                             want.assigned_id));
          if (seen.is_new_track !== want.is_new_track)
            report($sformatf("is_new_track got %b want %b (id %0d)", seen.is_new_track,
                             want.is_new_track, want.assigned_id));
          if (seen.table_full !== want.table_full)
            report($sformatf("table_full got %b want %b (id %0d)", seen.table_full,
                             want.table_full, want.assigned_id));
        end
      end

      if (in_valid && in_ready) begin
        if (in_operation == OP_DETECTION)
          expected_ids = {expected_ids, associate(in_pos_x, in_pos_y, in_target_size)};
        else
          age_tracks();
      end
    end
    pending = expected_ids.size();
  end

endmodule

>>> tb/nearest_neighbor_track_table_test.sv
// Top of the track table testbench: clock, reset, stimulus, register phases and
// verdict. Instantiates nearest_neighbor_track_table and nntt_checker; uses nntt_pkg.
module nearest_neighbor_track_table_test import nntt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TRACKS     = 16;
  localparam int SETTLE_CYCLES  = 2 * (MAX_TRACKS + 8);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_OBJECTS    = 12;
  localparam int POS_MAX        = (1 << POS_W) - 1;
  localparam int AREA_MAX       = (1 << AREA_W) - 1;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  logic                  in_operation     = OP_FRAME_START;
  logic [POS_W-1:0]      in_pos_x         = '0;
  logic [POS_W-1:0]      in_pos_y         = '0;
  logic [AREA_W-1:0]     in_target_size   = '0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  logic [ID_W-1:0]       out_assigned_id;
  logic                  out_is_new_track;
  logic                  out_table_full;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = CFG_GATE_DISTANCE;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   stall_left  = 0;
  logic rx_steady   = 1'b0;
  bit   tx_steady   = 1'b0;
  int   items_sent  = 0;

  int   obj_x    [MAX_OBJECTS];
  int   obj_y    [MAX_OBJECTS];
  int   obj_area [MAX_OBJECTS];

  nearest_neighbor_track_table #(.MAX_TRACKS(MAX_TRACKS)) u_top (.*);

  nntt_checker #(.TRACKS(MAX_TRACKS)) u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_area();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, AREA_MAX);
    return $urandom_range(1, 1 << $urandom_range(2, AREA_W - 1));
  endfunction

  function automatic int nudge(input int v, input int span, input int limit);
    int n;
    n = v + int'($urandom_range(0, 2 * span)) - span;
    return (n < 0) ? 0 : (n > limit) ? limit : n;
  endfunction

  // result side: random stalls, with stretches of none
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
    if ($urandom_range(0, 299) == 0) rx_steady <= !rx_steady;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_item(input logic op, input int x, input int y, input int area);
    if (!tx_steady && $urandom_range(0, 1) == 0) begin
      in_valid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_pos_x       <= POS_W'(x);
    in_pos_y       <= POS_W'(y);
    in_target_size <= AREA_W'(area);
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // position and size fields are don't-care here, so scramble them
  task automatic send_frame_start();
    send_item(OP_FRAME_START, $urandom, $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_config(input int gate, input int ratio, input int misses);
    write_reg(CFG_GATE_DISTANCE, gate);
    write_reg(CFG_MIN_SIZE_RATIO, ratio);
    write_reg(CFG_MAX_MISSES, misses);
    cfg_valid <= 1'b0;
  endtask

  // hold off until every result is back, then let the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(OP_DETECTION, 0, 0, 0);                    // first track
    send_item(OP_DETECTION, 0, 0, 0);                    // zero areas match
    send_item(OP_DETECTION, POS_MAX, POS_MAX, AREA_MAX); // far corner
    send_item(OP_DETECTION, 800, 0, 0);                  // exactly on the gate
    send_item(OP_DETECTION, 1601, 0, 0);                 // one step outside it
    send_item(OP_DETECTION, POS_MAX, POS_MAX, 0);        // size ratio fails
    send_item(OP_DETECTION, 1000, 5000, 100);
    send_item(OP_DETECTION, 1200, 5000, 150);            // too large for the last one
    send_item(OP_DETECTION, 1100, 5000, 122);            // equal distance, lower id wins
    send_item(OP_DETECTION, 1180, 5000, 140);            // later but nearer track wins
    repeat (4) send_frame_start();
    send_item(OP_DETECTION, 1180, 5000, 140);            // keeps one, prunes the rest
    repeat (9) send_frame_start();                       // misses saturate
    send_item(OP_DETECTION, POS_MAX, 0, AREA_MAX);
    send_item(OP_DETECTION, 0, POS_MAX, 1);
  endtask

  task automatic run_phase(input int n_items, input int n_obj, input int span);
    int start, k;
    start = items_sent;
    for (k = 0; k < n_obj; k++) begin
      obj_x[k]    = $urandom_range(0, POS_MAX);
      obj_y[k]    = $urandom_range(0, POS_MAX);
      obj_area[k] = pick_area();
    end
    while (items_sent - start < n_items) begin
      tx_steady = ($urandom_range(0, 4) == 0);
      send_frame_start();
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) send_frame_start();
      for (k = 0; k < n_obj; k++) begin
        if ($urandom_range(0, 9) < 8) begin
          obj_x[k] = nudge(obj_x[k], span, POS_MAX);
          obj_y[k] = nudge(obj_y[k], span, POS_MAX);
          if ($urandom_range(0, 3) == 0)
            obj_area[k] = nudge(obj_area[k], obj_area[k] / 6, AREA_MAX);
          send_item(OP_DETECTION, obj_x[k], obj_y[k], obj_area[k]);
        end
      end
      if ($urandom_range(0, 2) == 0) send_item(1'($urandom), $urandom, $urandom, $urandom);
      // replace a target now and then
      if ($urandom_range(0, 5) == 0) begin
        k           = $urandom_range(0, n_obj - 1);
        obj_x[k]    = $urandom_range(0, POS_MAX);
        obj_y[k]    = $urandom_range(0, POS_MAX);
        obj_area[k] = pick_area();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    drain_results();
    program_config(800, 179, 3);
    run_phase(170, 6, 300);
    drain_results();
    program_config(0, 256, 6);
    run_phase(160, 10, 0);
    drain_results();
    program_config(POS_MAX, 0, 0);
    run_phase(160, 4, 4000);
    drain_results();
    program_config($urandom_range(0, 3000), $urandom_range(0, 256), $urandom_range(0, 6));
    run_phase(170, 12, 500);
    drain_results();
    program_config(2000, 128, 2);
    run_phase(150, 8, 1000);
    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
